// ===== src/pbps_pkg.sv =====
// Shared package for the priority based process selector.
// Holds slot table sizes, event and status codes, the slot record and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package pbps_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int SLOT_W    = 6;
    localparam int PRIO_W    = 7;
    localparam int MODE_W    = 3;
    localparam int NS_W      = 2;
    localparam int TICK_W    = 32;
    localparam int NUM_W     = TICK_W + 4;   // holds 10 * wait
    localparam int NICE_W    = 4;
    localparam int QBIT_W    = 2;

    localparam logic [PRIO_W-1:0] DEFAULT_SP  = 7'd60;
    localparam logic [NICE_W-1:0] NICE_NO_RUN = 4'd5;

    // Event codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SETST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SETPR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCHED  = 3'd4;

    // Requested state codes for set state
    localparam logic [NS_W-1:0] NS_RUNNABLE = 2'd0;
    localparam logic [NS_W-1:0] NS_SLEEPING = 2'd1;
    localparam logic [NS_W-1:0] NS_FREE     = 2'd2;
    localparam logic [NS_W-1:0] NS_INVALID  = 2'd3;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_SLEEPING = 2'd2,
        ST_RUNNING  = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] sp;   // static priority
        logic [TICK_W-1:0] run;  // run ticks
        logic [TICK_W-1:0] st;   // start tick
        logic [TICK_W-1:0] et;   // end tick
        logic [TICK_W-1:0] rc;   // run count
        logic [TICK_W-1:0] ct;   // create tick
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [1:0] {
        ADDR_SLOT = 2'd0,
        ADDR_RUN  = 2'd1,
        ADDR_SCAN = 2'd2,
        ADDR_BEST = 2'd3
    } t_addr_sel;

    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_CREATE = 3'd1,
        WR_TICK   = 3'd2,
        WR_END    = 3'd3,
        WR_PRIO   = 3'd4,
        WR_START  = 3'd5
    } t_wr_op;

    typedef struct packed {
        logic      load;
        logic      tick_inc;
        t_addr_sel addr_sel;
        t_wr_op    wr_op;
        logic      set_state;
        logic      scan_init;
        logic      scan_prep;
        logic      scan_prep2;
        logic      div_step;
        logic      scan_cmp;
        logic      scan_next;
        logic      emit;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              slot_ok;
        t_status           slot_st;
        logic              ns_ok;
        logic              run_vld;
        logic              scan_free;
        logic              cand_zero;
        logic              div_last;
        logic              scan_last;
        logic              have;
    } t_sts;

endpackage

// ===== src/priority_based_process_selector_top.sv =====
// Top level of the priority based process selector.
// Depends on pbps_pkg, pbps_ctrl, pbps_dp (which holds pbps_ram).
//
// Channel    Ports                                           Handshake
// config     i_cfg_we, i_cfg_wdata                           write when i_cfg_we
// event      i_start, o_busy, i_mode, i_slot,                taken when i_start & !o_busy
//            i_priority_value, i_next_state
// result     o_valid, o_found, o_chosen_slot,                one-cycle strobe o_valid
//            o_chosen_priority, o_prev_priority, o_preempt
//
// Every event transaction yields exactly one result transaction.
// Schedule: when no slot is running, a scan of the slot record RAM, one slot at a
// time; a used slot is read, prepared, passed through 4 divider steps (skipped if
// it has no run ticks) and compared; a free slot is only read and passed over.
// Reset (synchronous, i_rst_n low) frees all slots, clears the tick counter,
// leaves no slot running and loads the default static priority 60.
// The receiver cannot stall: o_valid is high for exactly one cycle.
`timescale 1ns / 1ps
module priority_based_process_selector_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pbps_pkg::PRIO_W-1:0] i_cfg_wdata,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [pbps_pkg::MODE_W-1:0] i_mode,
    input  logic [pbps_pkg::SLOT_W-1:0] i_slot,
    input  logic [pbps_pkg::PRIO_W-1:0] i_priority_value,
    input  logic [pbps_pkg::NS_W-1:0]   i_next_state,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [pbps_pkg::SLOT_W-1:0] o_chosen_slot,
    output logic [pbps_pkg::PRIO_W-1:0] o_chosen_priority,
    output logic [pbps_pkg::PRIO_W-1:0] o_prev_priority,
    output logic                        o_preempt
);
    import pbps_pkg::*;

    // Commands from the controller, status back from the datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence each event transaction
    pbps_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd),
        .o_busy (o_busy)
    );

    // Hold slot table, compute dynamic priorities, track the best slot
    pbps_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_mode),
        .i_slot           (i_slot),
        .i_priority_value (i_priority_value),
        .i_next_state     (i_next_state),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_chosen_slot    (o_chosen_slot),
        .o_chosen_priority(o_chosen_priority),
        .o_prev_priority  (o_prev_priority),
        .o_preempt        (o_preempt)
    );

endmodule

// ===== src/pbps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pbps_ctrl.sv =====
// Controller state machine of the process selector.
// Depends on pbps_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps
module pbps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pbps_pkg::t_sts i_sts,
    output pbps_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import pbps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC,
        S_TK_RD, S_TK_WR,
        S_SS_RD, S_SS_WR,
        S_SP_RD, S_SP_WR,
        S_SC_RD, S_SC_PREP, S_SC_PREP2, S_SC_DIV, S_SC_CMP, S_SC_NEXT,
        S_PK_RD, S_PK_WR,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_EMIT;
                case (i_sts.mode)
                    MODE_TICK: begin
                        w_cmd.tick_inc = 1'b1;
                        if (i_sts.run_vld) n_state = S_TK_RD;
                    end
                    MODE_CREATE: begin
                        if (i_sts.slot_ok && i_sts.slot_st == ST_FREE) begin
                            w_cmd.addr_sel = ADDR_SLOT;
                            w_cmd.wr_op    = WR_CREATE;
                        end
                    end
                    MODE_SETST: begin
                        if (i_sts.slot_ok && i_sts.slot_st != ST_FREE && i_sts.ns_ok) begin
                            if (i_sts.slot_st == ST_RUNNING) begin
                                n_state = S_SS_RD;
                            end else begin
                                w_cmd.set_state = 1'b1;
                            end
                        end
                    end
                    MODE_SETPR: begin
                        if (i_sts.slot_ok && i_sts.slot_st != ST_FREE) n_state = S_SP_RD;
                    end
                    MODE_SCHED: begin
                        if (!i_sts.run_vld) begin
                            w_cmd.scan_init = 1'b1;
                            n_state         = S_SC_RD;
                        end
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_TK_RD: begin
                w_cmd.addr_sel = ADDR_RUN;
                n_state        = S_TK_WR;
            end
            S_TK_WR: begin
                w_cmd.addr_sel = ADDR_RUN;
                w_cmd.wr_op    = WR_TICK;
                n_state        = S_EMIT;
            end
            S_SS_RD: begin
                w_cmd.addr_sel = ADDR_SLOT;
                n_state        = S_SS_WR;
            end
            S_SS_WR: begin
                w_cmd.addr_sel = ADDR_SLOT;
                w_cmd.wr_op    = WR_END;
                n_state        = S_EMIT;
            end
            S_SP_RD: begin
                w_cmd.addr_sel = ADDR_SLOT;
                n_state        = S_SP_WR;
            end
            S_SP_WR: begin
                w_cmd.addr_sel = ADDR_SLOT;
                w_cmd.wr_op    = WR_PRIO;
                n_state        = S_EMIT;
            end
            S_SC_RD: begin
                w_cmd.addr_sel = ADDR_SCAN;
                n_state        = S_SC_PREP;
            end
            S_SC_PREP: begin
                if (i_sts.scan_free) begin
                    n_state = S_SC_NEXT;
                end else begin
                    w_cmd.scan_prep = 1'b1;
                    n_state         = S_SC_PREP2;
                end
            end
            S_SC_PREP2: begin
                w_cmd.scan_prep2 = 1'b1;
                n_state          = i_sts.cand_zero ? S_SC_CMP : S_SC_DIV;
            end
            S_SC_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_SC_CMP;
            end
            S_SC_CMP: begin
                w_cmd.scan_cmp = 1'b1;
                n_state        = S_SC_NEXT;
            end
            S_SC_NEXT: begin
                if (i_sts.scan_last) begin
                    n_state = i_sts.have ? S_PK_RD : S_EMIT;
                end else begin
                    w_cmd.scan_next = 1'b1;
                    n_state         = S_SC_RD;
                end
            end
            S_PK_RD: begin
                w_cmd.addr_sel = ADDR_BEST;
                n_state        = S_PK_WR;
            end
            S_PK_WR: begin
                w_cmd.addr_sel = ADDR_BEST;
                w_cmd.wr_op    = WR_START;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                w_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/pbps_dp.sv =====
// Datapath of the process selector: slot record RAM, status flops, tick
// counter, dynamic priority unit with a radix-2 divider, best-slot tracking.
// Depends on pbps_pkg and pbps_ram.
`timescale 1ns / 1ps
module pbps_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pbps_pkg::PRIO_W-1:0] i_cfg_wdata,
    input  logic [pbps_pkg::MODE_W-1:0] i_mode,
    input  logic [pbps_pkg::SLOT_W-1:0] i_slot,
    input  logic [pbps_pkg::PRIO_W-1:0] i_priority_value,
    input  logic [pbps_pkg::NS_W-1:0]   i_next_state,
    input  pbps_pkg::t_cmd              i_cmd,
    output pbps_pkg::t_sts              o_sts,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [pbps_pkg::SLOT_W-1:0] o_chosen_slot,
    output logic [pbps_pkg::PRIO_W-1:0] o_chosen_priority,
    output logic [pbps_pkg::PRIO_W-1:0] o_prev_priority,
    output logic                        o_preempt
);
    import pbps_pkg::*;

    function automatic t_status ns_to_status(input logic [NS_W-1:0] ns);
        t_status s;
        case (ns)
            NS_RUNNABLE: s = ST_RUNNABLE;
            NS_SLEEPING: s = ST_SLEEPING;
            default:     s = ST_FREE;
        endcase
        return s;
    endfunction

    // Control registers
    logic [PRIO_W-1:0] r_default_sp;
    logic [TICK_W-1:0] r_tick;
    logic              r_run_vld;
    logic              r_valid;
    t_status           r_status [NUM_SLOTS];

    // Event and scan registers
    logic [MODE_W-1:0] r_mode;
    logic [SLOT_W-1:0] r_slot;
    logic [PRIO_W-1:0] r_pv;
    logic [NS_W-1:0]   r_ns;
    logic [IDX_W-1:0]  r_run_idx;
    logic [IDX_W-1:0]  r_idx;
    logic              r_have;
    logic [IDX_W-1:0]  r_best_idx;
    logic [PRIO_W-1:0] r_best_dp;
    logic [TICK_W-1:0] r_best_rc;
    logic [TICK_W-1:0] r_best_ct;
    logic [PRIO_W-1:0] r_c_sp;
    logic [TICK_W-1:0] r_c_rc;
    logic [TICK_W-1:0] r_c_ct;
    logic              r_c_runnable;
    logic              r_c_zero;
    logic [TICK_W-1:0] r_span;
    logic [TICK_W-1:0] r_run;
    logic [NUM_W-1:0]  r_rem;
    logic [TICK_W-1:0] r_den;
    logic [NICE_W-1:0] r_q;
    logic [QBIT_W-1:0] r_bit;

    // Result registers
    logic              r_found;
    logic [SLOT_W-1:0] r_chosen_slot;
    logic [PRIO_W-1:0] r_chosen_prio;
    logic [PRIO_W-1:0] r_prev_prio;
    logic              r_preempt;

    logic [IDX_W-1:0]  w_slot_idx;
    logic              w_slot_ok;
    logic [IDX_W-1:0]  w_addr;
    logic [REC_W-1:0]  w_rdata_raw;
    t_rec              w_rd;
    t_rec              w_wr;
    logic              w_we;
    logic [TICK_W-1:0] w_wait;
    logic [NUM_W-1:0]  w_shifted;
    logic [NICE_W-1:0] w_nice;
    logic signed [PRIO_W+1:0] w_dpv;
    logic [PRIO_W-1:0] w_dp;
    logic              w_better;

    assign w_slot_idx = IDX_W'(r_slot);
    assign w_slot_ok  = (int'(r_slot) < NUM_SLOTS);

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_SLOT: w_addr = w_slot_idx;
            ADDR_RUN:  w_addr = r_run_idx;
            ADDR_SCAN: w_addr = r_idx;
            ADDR_BEST: w_addr = r_best_idx;
            default:   w_addr = w_slot_idx;
        endcase
    end

    assign w_rd = t_rec'(w_rdata_raw);

    always_comb begin
        w_wr = w_rd;
        w_we = 1'b1;
        case (i_cmd.wr_op)
            WR_CREATE: begin
                w_wr.sp  = r_default_sp;
                w_wr.run = '0;
                w_wr.st  = '0;
                w_wr.et  = '0;
                w_wr.rc  = '0;
                w_wr.ct  = r_tick;
            end
            WR_TICK:  w_wr.run = w_rd.run + 1'b1;
            WR_END:   w_wr.et  = r_tick;
            WR_PRIO:  w_wr.sp  = r_pv;
            WR_START: begin
                w_wr.st  = r_tick;
                w_wr.rc  = w_rd.rc + 1'b1;
                w_wr.run = '0;
            end
            default: w_we = 1'b0;
        endcase
    end

    pbps_ram #(
        .WIDTH(REC_W),
        .DEPTH(NUM_SLOTS)
    ) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_addr),
        .i_wdata(REC_W'(w_wr)),
        .i_raddr(w_addr),
        .o_rdata(w_rdata_raw)
    );

    // Dynamic priority arithmetic
    assign w_wait    = (r_span > r_run) ? (r_span - r_run) : '0;
    assign w_shifted = NUM_W'(r_den) << r_bit;
    assign w_nice    = r_c_zero ? NICE_NO_RUN : r_q;
    assign w_dpv     = $signed({2'b00, r_c_sp}) + (PRIO_W+2)'(5)
                     - $signed({(PRIO_W+2-NICE_W)'(0), w_nice});

    always_comb begin
        if (w_dpv < 0) begin
            w_dp = '0;
        end else if (w_dpv > (PRIO_W+2)'(100)) begin
            w_dp = PRIO_W'(100);
        end else begin
            w_dp = w_dpv[PRIO_W-1:0];
        end
    end

    assign w_better = !r_have || (w_dp < r_best_dp) ||
                      ((w_dp == r_best_dp) &&
                       ((r_c_rc > r_best_rc) ||
                        ((r_c_rc == r_best_rc) && (r_c_ct < r_best_ct))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_sp <= DEFAULT_SP;
            r_tick       <= '0;
            r_run_vld    <= 1'b0;
            r_valid      <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_status[k] <= ST_FREE;
            end
        end else begin
            if (i_cfg_we) r_default_sp <= i_cfg_wdata;
            if (i_cmd.tick_inc) r_tick <= r_tick + 1'b1;
            r_valid <= i_cmd.emit;
            if (i_cmd.wr_op == WR_CREATE) r_status[w_slot_idx] <= ST_RUNNABLE;
            if (i_cmd.set_state || i_cmd.wr_op == WR_END) begin
                r_status[w_slot_idx] <= ns_to_status(r_ns);
            end
            if (i_cmd.wr_op == WR_END) r_run_vld <= 1'b0;
            if (i_cmd.wr_op == WR_START) begin
                r_status[r_best_idx] <= ST_RUNNING;
                r_run_vld            <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode        <= i_mode;
            r_slot        <= i_slot;
            r_pv          <= i_priority_value;
            r_ns          <= i_next_state;
            r_found       <= 1'b0;
            r_chosen_slot <= '0;
            r_chosen_prio <= '0;
            r_prev_prio   <= '0;
            r_preempt     <= 1'b0;
        end
        if (i_cmd.wr_op == WR_PRIO) begin
            r_prev_prio <= w_rd.sp;
            r_preempt   <= (w_rd.sp < r_pv);
        end
        if (i_cmd.wr_op == WR_START) begin
            r_run_idx     <= r_best_idx;
            r_found       <= 1'b1;
            r_chosen_slot <= SLOT_W'(r_best_idx);
            r_chosen_prio <= r_best_dp;
        end
        if (i_cmd.scan_init) begin
            r_idx  <= '0;
            r_have <= 1'b0;
        end
        if (i_cmd.scan_next) r_idx <= r_idx + 1'b1;
        if (i_cmd.scan_prep) begin
            r_span       <= w_rd.et - w_rd.st;
            r_run        <= w_rd.run;
            r_c_zero     <= (w_rd.run == '0);
            r_c_sp       <= w_rd.sp;
            r_c_rc       <= w_rd.rc;
            r_c_ct       <= w_rd.ct;
            r_c_runnable <= (r_status[r_idx] == ST_RUNNABLE);
        end
        if (i_cmd.scan_prep2) begin
            // den = run + wait, which is the larger of span and run
            r_den <= (r_span > r_run) ? r_span : r_run;
            r_rem <= (NUM_W'(w_wait) << 3) + (NUM_W'(w_wait) << 1);
            r_q   <= '0;
            r_bit <= QBIT_W'(NICE_W - 1);
        end
        if (i_cmd.div_step) begin
            if (r_rem >= w_shifted) begin
                r_rem        <= r_rem - w_shifted;
                r_q[r_bit]   <= 1'b1;
            end
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.scan_cmp && r_c_runnable && w_better) begin
            r_have     <= 1'b1;
            r_best_idx <= r_idx;
            r_best_dp  <= w_dp;
            r_best_rc  <= r_c_rc;
            r_best_ct  <= r_c_ct;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.mode      = r_mode;
        o_sts.slot_ok   = w_slot_ok;
        o_sts.slot_st   = r_status[w_slot_idx];
        o_sts.ns_ok     = (r_ns != NS_INVALID);
        o_sts.run_vld   = r_run_vld;
        o_sts.scan_free = (r_status[r_idx] == ST_FREE);
        o_sts.cand_zero = r_c_zero;
        o_sts.div_last  = (r_bit == '0);
        o_sts.scan_last = (r_idx == IDX_W'(NUM_SLOTS - 1));
        o_sts.have      = r_have;
    end

    assign o_valid           = r_valid;
    assign o_found           = r_found;
    assign o_chosen_slot     = r_chosen_slot;
    assign o_chosen_priority = r_chosen_prio;
    assign o_prev_priority   = r_prev_prio;
    assign o_preempt         = r_preempt;

endmodule

// ===== src/pbps_checker.sv =====
// Port-level checker for the process selector, bound to the top level.
// Depends on pbps_pkg and priority_based_process_selector_top.
`timescale 1ns / 1ps
module pbps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_valid,
    input logic                        o_found,
    input logic [pbps_pkg::SLOT_W-1:0] o_chosen_slot,
    input logic [pbps_pkg::PRIO_W-1:0] o_chosen_priority,
    input logic [pbps_pkg::PRIO_W-1:0] o_prev_priority,
    input logic                        o_preempt
);
    import pbps_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after accept");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_no_pick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_chosen_slot == '0 && o_chosen_priority == '0))
        else $error("chosen fields set without a pick");

    a_prio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_chosen_priority <= PRIO_W'(100)))
        else $error("dynamic priority out of range");

    a_pick_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (!o_preempt && o_prev_priority == '0))
        else $error("pick result carries set priority fields");

endmodule

bind priority_based_process_selector_top pbps_checker u_pbps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_valid          (o_valid),
    .o_found          (o_found),
    .o_chosen_slot    (o_chosen_slot),
    .o_chosen_priority(o_chosen_priority),
    .o_prev_priority  (o_prev_priority),
    .o_preempt        (o_preempt)
);
